// ===== rtl/wvi_pkg.sv =====
// Shared types and constants for the weighted volume integral block.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package wvi_pkg;

  // Metric entries are fixed at Q4.12 on the ports.
  localparam int ENTRY_W = 16;
  localparam int ROOT_W = 24;
  localparam int SAMPLE_W = 24;
  localparam int TOTAL_W = 48;

  // Shared multiplier: signed A by signed B.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 34;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // A 2x2 minor needs 33 bits; the 3x3 determinant stays below 2^48.
  localparam int MINOR_W = 34;
  localparam int DET_W = 50;
  localparam int DET_SHIFT = 4;

  // Digit-by-digit square root, one result bit per step.
  localparam int SQRT_STEPS = 24;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam int RAD_W = 2 * SQRT_STEPS;
  localparam int REM_W = SQRT_STEPS + 2;

  // Sample times element is Q.32; the Q.16 product keeps bits [47:16].
  localparam int PROD_LSB = 16;
  localparam int PROD_W = 32;

  typedef struct packed {
    logic signed [ROOT_W-1:0]   given_root;
    logic signed [ENTRY_W-1:0]  m00;
    logic signed [ENTRY_W-1:0]  m01;
    logic signed [ENTRY_W-1:0]  m02;
    logic signed [ENTRY_W-1:0]  m10;
    logic signed [ENTRY_W-1:0]  m11;
    logic signed [ENTRY_W-1:0]  m12;
    logic signed [ENTRY_W-1:0]  m20;
    logic signed [ENTRY_W-1:0]  m21;
    logic signed [ENTRY_W-1:0]  m22;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       final_point;
  } in_word_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic                      overflowed;
  } out_word_t;

  // Operand pairs of the shared multiplier, in determinant order.
  typedef enum logic [3:0] {
    MS_EK,
    MS_FH,
    MS_AT,
    MS_DK,
    MS_FG,
    MS_BT,
    MS_DH,
    MS_EG,
    MS_CT,
    MS_SE
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DET,
    ST_SQI,
    ST_SQRT,
    ST_MUL,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t sel;
    logic     det_en;
    logic     sqrt_init;
    logic     sqrt_en;
    logic     mul_en;
    logic     acc_en;
  } dp_cmd_t;

  typedef struct packed {
    logic root_pos;
    logic final_pt;
    logic out_full;
  } dp_stat_t;

endpackage

// ===== rtl/wvi_ctrl.sv =====
// Sequencer for the weighted volume integral block.
// Steps the datapath through determinant, square root, product and add.
// Depends on wvi_pkg.
module wvi_ctrl
  import wvi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t                state_r, state_nxt;
  mul_sel_t              sel_r, sel_nxt;
  logic [SQRT_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= MS_EK;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.sel   = sel_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          sel_nxt     = MS_EK;
          state_nxt   = ST_DET;
        end
      end
      ST_DET: begin
        // A positive given root bypasses the determinant entirely.
        if (stat.root_pos) begin
          state_nxt = ST_MUL;
        end else begin
          cmd.det_en = 1'b1;
          case (sel_r)
            MS_EK:   sel_nxt = MS_FH;
            MS_FH:   sel_nxt = MS_AT;
            MS_AT:   sel_nxt = MS_DK;
            MS_DK:   sel_nxt = MS_FG;
            MS_FG:   sel_nxt = MS_BT;
            MS_BT:   sel_nxt = MS_DH;
            MS_DH:   sel_nxt = MS_EG;
            MS_EG:   sel_nxt = MS_CT;
            default: sel_nxt = MS_EK;
          endcase
          if (sel_r == MS_CT) begin
            state_nxt = ST_SQI;
          end
        end
      end
      ST_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_en = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.sel    = MS_SE;
        cmd.mul_en = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        // A final point waits here until the output register can take its word.
        if (!(stat.final_pt && stat.out_full)) begin
          cmd.acc_en = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/wvi_dp.sv =====
// Datapath of the weighted volume integral block: input register, shared
// multiplier, determinant, bit-serial square root, saturating accumulator.
// Depends on wvi_pkg.
module wvi_dp
  import wvi_pkg::*;
#(
  parameter int SUM_WIDTH = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  input  logic      out_stall,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_word_t out_data
);

  in_word_t                    in_r;
  logic signed [MINOR_W-1:0]   minor_r, minor_nxt;
  logic signed [DET_W-1:0]     det_r, det_nxt;
  logic [RAD_W-1:0]            rad_r;
  logic [REM_W-1:0]            rem_r;
  logic [SQRT_STEPS-1:0]       root_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [SUM_WIDTH-1:0] sum_r;
  logic                        sat_r;
  logic                        out_valid_r;
  out_word_t                   out_data_r;

  logic signed [MUL_A_W-1:0]   op_a;
  logic signed [MUL_B_W-1:0]   op_b;
  logic signed [MUL_P_W-1:0]   mul_p;
  logic [SQRT_STEPS-1:0]       elem;
  logic                        root_pos;

  logic [REM_W+1:0]            rem_sh;
  logic [REM_W+1:0]            trial;

  logic signed [SUM_WIDTH:0]   acc_sum;
  logic                        ovf;
  logic signed [SUM_WIDTH-1:0] new_sum;
  logic signed [63:0]          total_ext;

  assign root_pos = !in_r.given_root[ROOT_W-1] && (|in_r.given_root);
  assign elem     = root_pos ? SQRT_STEPS'(unsigned'(in_r.given_root)) : root_r;

  // Letters follow the usual cofactor names: a b c / d e f / g h k.
  always_comb begin
    case (cmd.sel)
      MS_EK: begin op_a = MUL_A_W'(in_r.m11); op_b = MUL_B_W'(in_r.m22); end
      MS_FH: begin op_a = MUL_A_W'(in_r.m12); op_b = MUL_B_W'(in_r.m21); end
      MS_AT: begin op_a = MUL_A_W'(in_r.m00); op_b = MUL_B_W'(minor_r); end
      MS_DK: begin op_a = MUL_A_W'(in_r.m10); op_b = MUL_B_W'(in_r.m22); end
      MS_FG: begin op_a = MUL_A_W'(in_r.m12); op_b = MUL_B_W'(in_r.m20); end
      MS_BT: begin op_a = MUL_A_W'(in_r.m01); op_b = MUL_B_W'(minor_r); end
      MS_DH: begin op_a = MUL_A_W'(in_r.m10); op_b = MUL_B_W'(in_r.m21); end
      MS_EG: begin op_a = MUL_A_W'(in_r.m11); op_b = MUL_B_W'(in_r.m20); end
      MS_CT: begin op_a = MUL_A_W'(in_r.m02); op_b = MUL_B_W'(minor_r); end
      MS_SE: begin
        op_a = MUL_A_W'(in_r.sample_value);
        op_b = MUL_B_W'($signed({1'b0, elem}));
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mul_p = op_a * op_b;

  always_comb begin
    minor_nxt = minor_r;
    det_nxt   = det_r;
    case (cmd.sel)
      MS_EK, MS_DK, MS_DH: minor_nxt = MINOR_W'(mul_p);
      MS_FH, MS_FG, MS_EG: minor_nxt = minor_r - MINOR_W'(mul_p);
      MS_AT:               det_nxt = DET_W'(mul_p);
      MS_BT:               det_nxt = det_r - DET_W'(mul_p);
      MS_CT:               det_nxt = det_r + DET_W'(mul_p);
      default: begin
        minor_nxt = minor_r;
        det_nxt   = det_r;
      end
    endcase
  end

  // Restoring square root: bring down two radicand bits, try root*4+1.
  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_r, 2'b01});

  // The sum overflows when the two top bits of the widened add disagree.
  assign acc_sum   = (SUM_WIDTH + 1)'(sum_r) + (SUM_WIDTH + 1)'(prod_r);
  assign ovf       = acc_sum[SUM_WIDTH] ^ acc_sum[SUM_WIDTH-1];
  assign new_sum   = !ovf ? acc_sum[SUM_WIDTH-1:0] :
                     acc_sum[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} :
                                          {1'b0, {(SUM_WIDTH-1){1'b1}}};
  assign total_ext = 64'(new_sum);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.det_en) begin
      minor_r <= minor_nxt;
      det_r   <= det_nxt;
    end
    if (cmd.sqrt_init) begin
      rad_r  <= (det_r > 0) ? RAD_W'(det_r >>> DET_SHIFT) : '0;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_en) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= REM_W'(rem_sh - trial);
        root_r <= {root_r[SQRT_STEPS-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(rem_sh);
        root_r <= {root_r[SQRT_STEPS-2:0], 1'b0};
      end
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p[PROD_LSB + PROD_W - 1:PROD_LSB];
    end
    if (cmd.acc_en && in_r.final_point) begin
      out_data_r.total      <= total_ext[TOTAL_W-1:0];
      out_data_r.overflowed <= sat_r | ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc_en) begin
        if (in_r.final_point) begin
          sum_r <= '0;
          sat_r <= 1'b0;
        end else begin
          sum_r <= new_sum;
          sat_r <= sat_r | ovf;
        end
      end
      if (cmd.acc_en && in_r.final_point) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.root_pos = root_pos;
  assign stat.final_pt = in_r.final_point;
  assign stat.out_full = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/weighted_volume_integral.sv =====
// Weighted volume integral: each grid point word adds sample_value times its
// volume element to a saturating Q.16 sum, and a point marked final_point
// releases one output word with the total and the overflow flag, then clears
// the sum. A point with a positive given_root skips the determinant and the
// square root and goes from the input register straight to the product; any
// other point first makes nine passes through the one shared multiplier to
// build the 3x3 determinant and then the 24 steps of the bit-serial square
// root. No new point is taken until the last is done. An output word waiting
// on out_stall holds up only the next final point, not the next point.
// Depends on wvi_pkg, wvi_ctrl and wvi_dp.
module weighted_volume_integral
  import wvi_pkg::*;
#(
  parameter int SUM_WIDTH = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wvi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  wvi_dp #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/wvi_checker.sv =====
// Port-level checks for weighted_volume_integral, bound to the top level.
// Depends on wvi_pkg.
module wvi_port_checks
  import wvi_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Final points accepted whose output word has not been taken yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_acc && in_data.final_point) - 2'(out_acc);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken again right after a word was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed or dropped");

  a_out_needs_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("output word without an accepted final point");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind weighted_volume_integral wvi_port_checks u_wvi_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
